// File: hw/rtl/bss_pkg.sv
// ---------------------------------------------------------------------------
// Bounded stack package
// Shared sizes, operation and status codes, and the cell control struct.
// ---------------------------------------------------------------------------
package bss_pkg;

    // Number of stack cells.
    localparam int DEPTH = 16;

    // Width of an entry count that can hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Width of a cell position.
    localparam int IDX_W = $clog2(DEPTH);

    // Fixed widths of the interface fields.
    localparam int WORD_W  = 32;
    localparam int CAP_W   = 5;
    localparam int FIDX_W  = 4;
    localparam int COUNT_W = 5;

    // Operation codes of the mode field.
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Shift control broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } bss_shift_t;

endpackage

// File: hw/rtl/bss_cfg.sv
// ---------------------------------------------------------------------------
// Bounded stack configuration port
// APB-style register holding the capacity, with its clamped working value.
// ---------------------------------------------------------------------------
module bss_cfg
    import bss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [CNT_W-1:0]    cap_eff
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic [31:0]      cap_wide;
    logic             cap_sel;

    // The register lives at byte address zero; address four is past the list.
    assign cap_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    // Register write on the access phase.
    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && cap_sel)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(16);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back the raw register value.
    assign prdata = cap_sel ? {{(32-CAP_W){1'b0}}, capacity_reg} : 32'd0;

    // Zero acts as one, and anything above the cell count acts as the cell count.
    always_comb
    begin
        cap_wide = {{(32-CAP_W){1'b0}}, capacity_reg};
        if (cap_wide == 32'd0)
        begin
            cap_wide = 32'd1;
        end
        else if (cap_wide > 32'(DEPTH))
        begin
            cap_wide = 32'(DEPTH);
        end
    end

    assign cap_eff = cap_wide[CNT_W-1:0];

endmodule

// File: hw/rtl/bss_cell.sv
// ---------------------------------------------------------------------------
// Bounded stack cell
// One stack entry: shifts with its neighbors, compares against the key, and
// passes a match-seen flag down the chain so only the topmost match wins.
// ---------------------------------------------------------------------------
module bss_cell
    import bss_pkg::*;
(
    input  logic              clk,
    input  bss_shift_t        shift,
    input  logic [WORD_W-1:0] word_above,
    input  logic [WORD_W-1:0] word_below,
    input  logic [WORD_W-1:0] key,
    input  logic              occupied,
    input  logic              seen_in,
    output logic              seen_out,
    output logic              first_hit,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              hit;

    // A push moves words toward the bottom, a pop toward the top.
    always_comb
    begin
        word_next = word_reg;
        if (shift.push)
        begin
            word_next = word_above;
        end
        else if (shift.pop)
        begin
            word_next = word_below;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Compare only held entries; the first hit from the top claims the match.
    assign hit       = occupied && (word_reg == key);
    assign first_hit = hit && !seen_in;
    assign seen_out  = seen_in || hit;
    assign word      = word_reg;

endmodule

// File: hw/rtl/bounded_stack_with_search.sv
// ---------------------------------------------------------------------------
// Bounded stack with search
// LIFO store of signed 32-bit words built as a shifting row of cells.
// ---------------------------------------------------------------------------
// Usage: drive mode and value and raise start for one cycle; the word is
// taken at that edge whenever busy is low. busy is always low, so a new
// command may be issued in every cycle. Modes are push, pop, search and
// status query.
// Results: the result word is registered on the result ports at the
// accepting edge and marked by done for a single cycle. Throughput is one
// command per cycle: the top cell holds the top of stack, so push, pop and
// the parallel compare in every cell all complete at the accepting edge.
// The receiver cannot stall; each result must be taken while done is high.
// Capacity is written through the APB port at address 0 (reset value 16);
// zero acts as one and values above the cell count act as the cell count.
// Reset empties the stack and clears done; no clearing pass is needed since
// only pushed cells are ever read.
// ---------------------------------------------------------------------------
module bounded_stack_with_search
    import bss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic signed [WORD_W-1:0] value,
    output logic                     done,
    output logic [1:0]               status,
    output logic                     found,
    output logic [FIDX_W-1:0]        found_index,
    output logic [COUNT_W-1:0]       entry_count,
    output logic                     is_empty,
    output logic                     is_full,
    output logic signed [WORD_W-1:0] top_word,
    output logic signed [WORD_W-1:0] bottom_word,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [CNT_W-1:0]  cap_eff;
    logic              accept;
    bss_shift_t        shift;
    logic [WORD_W-1:0] cell_word [DEPTH];
    logic [WORD_W-1:0] above     [DEPTH];
    logic [WORD_W-1:0] below     [DEPTH];
    logic [DEPTH:0]    seen;
    logic [DEPTH-1:0]  first_hit;
    logic [DEPTH-1:0]  occupied;

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [WORD_W-1:0] bottom_reg;
    logic [WORD_W-1:0] bottom_next;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              found_reg;
    logic              found_next;
    logic [FIDX_W-1:0] fidx_reg;
    logic [FIDX_W-1:0] fidx_next;
    logic [COUNT_W-1:0] count_reg;
    logic              empty_reg;
    logic              full_reg;
    logic [WORD_W-1:0] top_reg;
    logic [WORD_W-1:0] top_next;
    logic [WORD_W-1:0] bot_out_reg;
    logic [WORD_W-1:0] bot_out_next;

    logic [IDX_W-1:0]  hit_pos;
    logic [31:0]       fidx_wide;
    logic [31:0]       count_wide;

    // Configuration register.
    bss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cap_eff (cap_eff)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decide the shift and the status for this command.
    always_comb
    begin
        shift       = '0;
        status_next = ST_OK;
        fill_next   = fill_reg;
        case (mode)
            MODE_PUSH:
            begin
                if (fill_reg >= cap_eff)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    shift.push = accept;
                    fill_next  = fill_reg + CNT_W'(1);
                end
            end
            MODE_POP:
            begin
                if (fill_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    shift.pop = accept;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Row of cells, cell zero holding the top of stack.
    assign seen[0] = 1'b0;

    generate
        for (genvar k = 0; k < DEPTH; k++)
        begin : g_cell
            assign occupied[k] = (CNT_W'(k) < fill_reg);
            assign above[k]    = (k == 0) ? value : cell_word[(k == 0) ? 0 : k-1];
            assign below[k]    = (k == DEPTH-1) ? cell_word[k]
                                                : cell_word[(k == DEPTH-1) ? k : k+1];

            bss_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .word_above (above[k]),
                .word_below (below[k]),
                .key        (value),
                .occupied   (occupied[k]),
                .seen_in    (seen[k]),
                .seen_out   (seen[k+1]),
                .first_hit  (first_hit[k]),
                .word       (cell_word[k])
            );
        end
    endgenerate

    // Encode the winning cell; its position from the bottom is fill - 1 - k.
    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first_hit[k])
            begin
                hit_pos = hit_pos | IDX_W'(k);
            end
        end
    end

    assign fidx_wide  = 32'(fill_reg) - 32'd1 - 32'(hit_pos);
    assign count_wide = 32'(fill_next);

    always_comb
    begin
        found_next = 1'b0;
        fidx_next  = '0;
        if ((mode == MODE_SEARCH) && seen[DEPTH])
        begin
            found_next = 1'b1;
            fidx_next  = fidx_wide[FIDX_W-1:0];
        end
    end

    // Top and bottom words as they stand after the command.
    always_comb
    begin
        bottom_next = bottom_reg;
        if (shift.push && (fill_reg == '0))
        begin
            bottom_next = value;
        end

        if (shift.push)
        begin
            top_next = value;
        end
        else if (shift.pop)
        begin
            top_next = (fill_reg > CNT_W'(1)) ? cell_word[1] : '0;
        end
        else
        begin
            top_next = (fill_reg != '0) ? cell_word[0] : '0;
        end

        bot_out_next = (fill_next != '0) ? bottom_next : '0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Bottom word and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bottom_reg  <= bottom_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
            count_reg   <= count_wide[COUNT_W-1:0];
            empty_reg   <= (fill_next == '0);
            full_reg    <= (fill_next >= cap_eff);
            top_reg     <= top_next;
            bot_out_reg <= bot_out_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign entry_count = count_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign top_word    = top_reg;
    assign bottom_word = bot_out_reg;

`ifndef ASSERT_OFF
    // The stack never holds more entries than it has cells.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill level exceeds cell count");

    // Every accepted command yields one result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted command");

    // A successful push grows the fill level by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && shift.push) |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

    // Only a search can report a match.
    a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode != MODE_SEARCH)) |=> !found)
        else $error("match reported outside a search");
`endif

endmodule
